@@ rtl/delay_based_alpha_beta_adapt_top_defines.svh @@
`ifndef DELAY_BASED_ALPHA_BETA_ADAPT_TOP_DEFINES_SVH
`define DELAY_BASED_ALPHA_BETA_ADAPT_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define ABADAPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define ABADAPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/abadapt_pkg.sv @@
package abadapt_pkg;

  localparam logic [2:0] FUNC_INIT   = 3'd0;
  localparam logic [2:0] FUNC_SAMPLE = 3'd1;
  localparam logic [2:0] FUNC_ACK    = 3'd2;
  localparam logic [2:0] FUNC_LOSS   = 3'd3;
  localparam logic [2:0] FUNC_SSTH   = 3'd4;

  localparam logic [7:0] REG_WINDOW_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_GOOD_RTT_NEEDED  = 8'd1;

  localparam logic [31:0] RTT_CLAMP     = 32'd3355443;
  localparam logic [31:0] MIN_RTT_RESET = 32'h7fffffff;
  localparam logic [10:0] GAIN_MAX      = 11'd1280;
  localparam logic [10:0] GAIN_BASE     = 11'd128;
  localparam logic [5:0]  BETA_HI       = 6'd32;
  localparam logic [5:0]  BETA_LO       = 6'd6;
  localparam logic [31:0] GAIN_SPAN     = 32'd1242;  // GAIN_MAX - GAIN_MIN
  localparam logic [31:0] GAIN_MIN      = 32'd38;
  localparam logic [15:0] WTHR_RESET    = 16'd15;
  localparam logic [7:0]  GOOD_RESET    = 8'd5;

  // x / d == (x * ceil(2^(32+l) / d)) >> (32+l), l = ceil(log2 d), exact for 32-bit x
  localparam logic [32:0] RECIP_100    = 33'd5497558139;
  localparam int          RECIP_100_SH = 39;
  localparam logic [32:0] RECIP_20     = 33'd6871947674;
  localparam int          RECIP_20_SH  = 37;
  localparam logic [32:0] RECIP_10     = 33'd6871947674;
  localparam int          RECIP_10_SH  = 36;
  localparam logic [32:0] RECIP_38     = 33'd7233629131;
  localparam int          RECIP_38_SH  = 38;

  localparam int DIV_W = 38;

  typedef enum logic [0:0] {
    SEL_AVG, SEL_G2
  } div_sel_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] rtt_sample;
    logic [31:0]        ack_seq;
    logic [31:0]        next_seq;
    logic [31:0]        cwnd;
  } in_item_t;

  typedef struct packed {
    logic [10:0] alpha_gain;
    logic [5:0]  beta_factor;
    logic [31:0] ssthresh;
    logic        round_ended;
  } out_item_t;

  typedef struct packed {
    logic     div_start;
    div_sel_t div_sel;
    logic     ld_thr;
    logic     ld_g1;
    logic     ld_q1;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       round_hit;
    logic       below;
    logic       has_samples;
    logic       da_gt_d1;
    logic       den_zero;
    logic       div_idle;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

@@ rtl/abadapt_div.sv @@
module abadapt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [abadapt_pkg::DIV_W-1:0]  dividend,
  input  logic [31:0]                    divisor,
  output logic [abadapt_pkg::DIV_W-1:0]  quotient,
  output logic                           busy,
  output logic                           done
);

  localparam int CW = $clog2(abadapt_pkg::DIV_W);
  localparam logic [CW-1:0] LAST = CW'(abadapt_pkg::DIV_W - 1);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [CW-1:0] cnt;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem, quotient[abadapt_pkg::DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // restoring step: one quotient bit per cycle
        if (!diff[32]) begin
          rem      <= diff[31:0];
          quotient <= {quotient[abadapt_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[31:0];
          quotient <= {quotient[abadapt_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/abadapt_dp.sv @@
module abadapt_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_load,
  input  abadapt_pkg::in_item_t in_item,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  abadapt_pkg::cmd_t     cmd,
  output abadapt_pkg::stat_t    status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output abadapt_pkg::out_item_t out_item
);

  abadapt_pkg::in_item_t in_q;
  logic [15:0] window_threshold;
  logic [7:0]  good_rtt_needed;
  logic [31:0] min_rtt, peak_rtt, round_end_seq;
  logic [37:0] rtt_sum;
  logic [15:0] rtt_count;
  logic [10:0] gain_reg;
  logic [5:0]  beta_reg;
  logic [7:0]  low_rounds;
  logic        was_above;
  logic [31:0] da, d1, d2, d3, g1, q1, q2;
  abadapt_pkg::div_sel_t sel_q;

  logic [31:0] dm, dm8, dan, dmn, den, ack_diff, raw_u, r_clamp;
  logic [64:0] d1_prod, d2_prod, d3_prod, q1_prod;
  logic [42:0] g1_prod, num_prod;
  logic [abadapt_pkg::DIV_W-1:0] div_a, div_q;
  logic [31:0] div_b;
  logic        div_busy, div_done;

  logic [10:0] gain_new;
  logic [5:0]  beta_new;
  logic [7:0]  low_new, low_inc;
  logic        above_new;
  logic [37:0] ssth_prod;
  logic [31:0] ssth_a, ssth_h, ssth_val;
  abadapt_pkg::out_item_t out_next;

  assign dm       = peak_rtt - min_rtt;
  assign dm8      = {dm[28:0], 3'd0};  // 8*dm, wraps at 32 bits
  assign dan      = da - d1;
  assign dmn      = dm - d1;
  assign den      = dmn + q1;
  assign g1_prod  = {11'd0, dan} * {11'd0, abadapt_pkg::GAIN_SPAN[10:0]};
  assign num_prod = {11'd0, dmn} * {32'd0, abadapt_pkg::GAIN_MAX};
  assign d1_prod  = {33'd0, dm} * {32'd0, abadapt_pkg::RECIP_100};
  assign d2_prod  = {33'd0, dm} * {32'd0, abadapt_pkg::RECIP_20};
  assign d3_prod  = {33'd0, dm8} * {32'd0, abadapt_pkg::RECIP_10};
  assign q1_prod  = {33'd0, g1} * {32'd0, abadapt_pkg::RECIP_38};
  assign ack_diff = in_q.ack_seq - round_end_seq;
  assign raw_u    = $unsigned(in_q.rtt_sample);
  assign r_clamp  = (raw_u > abadapt_pkg::RTT_CLAMP) ? abadapt_pkg::RTT_CLAMP : raw_u;

  always_comb begin
    div_a = '0;
    div_b = '0;
    unique case (cmd.div_sel)
      abadapt_pkg::SEL_AVG: begin
        div_a = rtt_sum;
        div_b = {16'd0, rtt_count};
      end
      abadapt_pkg::SEL_G2: begin
        div_a = {6'd0, num_prod[31:0]};
        div_b = den;
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  abadapt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  // divider results and the constant-divisor stages
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel_q <= cmd.div_sel;
    end
    if (div_done) begin
      if (sel_q == abadapt_pkg::SEL_AVG) begin
        da <= div_q[31:0] - min_rtt;
      end else begin
        q2 <= div_q[31:0];
      end
    end
    if (cmd.ld_thr) begin
      d1 <= 32'(d1_prod >> abadapt_pkg::RECIP_100_SH);
      d2 <= 32'(d2_prod >> abadapt_pkg::RECIP_20_SH);
      d3 <= 32'(d3_prod >> abadapt_pkg::RECIP_10_SH);
    end
    if (cmd.ld_g1) begin
      g1 <= g1_prod[31:0];
    end
    if (cmd.ld_q1) begin
      q1 <= 32'(q1_prod >> abadapt_pkg::RECIP_38_SH);
    end
  end

  // gain and beta from a closed round with samples
  always_comb begin
    low_inc   = low_rounds + 8'd1;
    low_new   = low_rounds;
    above_new = was_above;
    gain_new  = abadapt_pkg::GAIN_MAX;
    if (!status.da_gt_d1) begin
      if (was_above) begin
        if (low_inc < good_rtt_needed) begin
          low_new  = low_inc;
          gain_new = gain_reg;
        end else begin
          low_new   = '0;
          above_new = 1'b0;
        end
      end
    end else begin
      above_new = 1'b1;
      if (den != 32'd0) begin
        gain_new = q2[10:0];
      end
    end
    beta_new = (da >= d3 || d3 <= d2) ? abadapt_pkg::BETA_HI : abadapt_pkg::BETA_LO;
  end

  assign ssth_prod = {6'd0, in_q.cwnd} * {32'd0, beta_reg};
  assign ssth_a    = in_q.cwnd - ssth_prod[37:6];
  assign ssth_h    = {1'b0, in_q.cwnd[31:1]};
  assign ssth_val  = (ssth_a > ssth_h) ? ssth_a : ssth_h;

  always_comb begin
    status.func        = in_q.func;
    status.round_hit   = (ack_diff != 32'd0) && !ack_diff[31];
    status.below       = in_q.cwnd < {16'd0, window_threshold};
    status.has_samples = rtt_count != 16'd0;
    status.da_gt_d1    = da > d1;
    status.den_zero    = den == 32'd0;
    status.div_idle    = !div_busy;
    status.div_done    = div_done;
    status.out_free    = !out_valid || !out_stall;
  end

  // result of the current item
  always_comb begin
    out_next             = '0;
    out_next.alpha_gain  = gain_reg;
    out_next.beta_factor = beta_reg;
    unique case (in_q.func)
      abadapt_pkg::FUNC_INIT: begin
        out_next.alpha_gain  = abadapt_pkg::GAIN_MAX;
        out_next.beta_factor = abadapt_pkg::BETA_HI;
      end
      abadapt_pkg::FUNC_ACK: begin
        if (status.round_hit) begin
          out_next.round_ended = 1'b1;
          if (status.below) begin
            out_next.alpha_gain  = abadapt_pkg::GAIN_BASE;
            out_next.beta_factor = abadapt_pkg::BETA_HI;
          end else if (status.has_samples) begin
            out_next.alpha_gain  = gain_new;
            out_next.beta_factor = beta_new;
          end
        end
      end
      abadapt_pkg::FUNC_LOSS: begin
        out_next.alpha_gain  = abadapt_pkg::GAIN_BASE;
        out_next.beta_factor = abadapt_pkg::BETA_HI;
      end
      abadapt_pkg::FUNC_SSTH: begin
        out_next.ssthresh = ssth_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_q <= in_item;
    end
    if (rst) begin
      window_threshold <= abadapt_pkg::WTHR_RESET;
      good_rtt_needed  <= abadapt_pkg::GOOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abadapt_pkg::REG_WINDOW_THRESHOLD: window_threshold <= cfg_data;
        abadapt_pkg::REG_GOOD_RTT_NEEDED:  good_rtt_needed  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rtt       <= abadapt_pkg::MIN_RTT_RESET;
      peak_rtt      <= '0;
      rtt_sum       <= '0;
      rtt_count     <= '0;
      round_end_seq <= '0;
      gain_reg      <= abadapt_pkg::GAIN_MAX;
      beta_reg      <= abadapt_pkg::BETA_HI;
      low_rounds    <= '0;
      was_above     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_item <= out_next;
        gain_reg <= out_next.alpha_gain;
        beta_reg <= out_next.beta_factor;
        unique case (in_q.func)
          abadapt_pkg::FUNC_INIT: begin
            min_rtt       <= abadapt_pkg::MIN_RTT_RESET;
            peak_rtt      <= '0;
            low_rounds    <= '0;
            was_above     <= 1'b0;
            round_end_seq <= in_q.next_seq;
            rtt_count     <= '0;
            rtt_sum       <= '0;
          end
          abadapt_pkg::FUNC_SAMPLE: begin
            if (!raw_u[31]) begin
              if (min_rtt > r_clamp) min_rtt <= r_clamp;
              if (peak_rtt < r_clamp) peak_rtt <= r_clamp;
              if (rtt_count != 16'hffff) begin
                rtt_count <= rtt_count + 16'd1;
                rtt_sum   <= rtt_sum + {6'd0, r_clamp};
              end
            end
          end
          abadapt_pkg::FUNC_ACK: begin
            if (status.round_hit) begin
              if (!status.below && status.has_samples) begin
                low_rounds <= low_new;
                was_above  <= above_new;
              end
              round_end_seq <= in_q.next_seq;
              rtt_count     <= '0;
              rtt_sum       <= '0;
            end
          end
          abadapt_pkg::FUNC_LOSS: begin
            low_rounds    <= '0;
            was_above     <= 1'b0;
            round_end_seq <= in_q.next_seq;
            rtt_count     <= '0;
            rtt_sum       <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/abadapt_ctrl.sv @@
`include "delay_based_alpha_beta_adapt_top_defines.svh"

module abadapt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  abadapt_pkg::stat_t status,
  output abadapt_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_W_AVG, S_CHK, S_G1B, S_G2_CHK, S_W_G2, S_COMMIT
  } state_t;

  state_t state, state_next;
  logic   in_wait;

  assign in_stall = state != S_IDLE;
  assign in_wait  = state == S_W_AVG || state == S_W_G2;

  always_comb begin
    state_next    = state;
    cmd.div_start = 1'b0;
    cmd.div_sel   = abadapt_pkg::SEL_AVG;
    cmd.ld_thr    = 1'b0;
    cmd.ld_g1     = 1'b0;
    cmd.ld_q1     = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC: begin
        if (status.func == abadapt_pkg::FUNC_ACK && status.round_hit &&
            !status.below && status.has_samples) begin
          cmd.div_start = 1'b1;
          state_next    = S_W_AVG;
        end else begin
          state_next = S_COMMIT;
        end
      end
      // average lands; delay thresholds taken at the same edge
      S_W_AVG: if (status.div_done) begin
        cmd.ld_thr = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (status.da_gt_d1) begin
          cmd.ld_g1  = 1'b1;
          state_next = S_G1B;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_G1B: begin
        cmd.ld_q1  = 1'b1;
        state_next = S_G2_CHK;
      end
      S_G2_CHK: begin
        if (status.den_zero) begin
          state_next = S_COMMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = abadapt_pkg::SEL_G2;
          state_next    = S_W_G2;
        end
      end
      S_W_G2: if (status.div_done) state_next = S_COMMIT;
      S_COMMIT: if (status.out_free) begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ABADAPT_ASSERT_NOW(a_commit_free, clk, rst, cmd.commit, status.out_free, "commit with full output")
  `ABADAPT_ASSERT_NOW(a_start_idle, clk, rst, cmd.div_start, status.div_idle, "divider busy at start")
  `ABADAPT_ASSERT_NOW(a_done_waiting, clk, rst, status.div_done, in_wait, "divider done outside wait")
  `ABADAPT_ASSERT_NEXT(a_accept_dec, clk, rst, state == S_IDLE && in_valid, state == S_DEC, "item lost")

endmodule

@@ rtl/delay_based_alpha_beta_adapt_top.sv @@
// Alpha/beta adaptation for a delay-based congestion controller.
// Input channel: in_valid / in_stall / in_item (func, rtt_sample, ack_seq,
// next_seq, cwnd). An item is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall / out_item, one result per item.
// Config: cfg_valid / cfg_ready / cfg_index / cfg_data; ready is always high,
// index 0 is window_threshold, 1 is good_rtt_needed. Write only when idle.
// Flow: simple events are decoded and their result is loaded directly. An
// ack that closes a round with samples runs the 38-step restoring divider
// for the average, reciprocal multiplies for the delay thresholds and gain
// term, then the divider again for the gain; a low-delay round skips the
// gain terms and a zero gain divisor skips the second division.
// One item is in flight; in_stall stays high until its result is loaded.
// A stalled result holds in the output register; the block still accepts
// the next item and finishes it, waiting before load until the slot frees.
// Reset (rst, synchronous): state and registers return to their defaults,
// no result pending.
module delay_based_alpha_beta_adapt_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  abadapt_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output abadapt_pkg::out_item_t out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  abadapt_pkg::cmd_t  cmd;
  abadapt_pkg::stat_t status;

  assign cfg_ready = 1'b1;

  abadapt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  abadapt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_load   (in_valid && !in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  abadapt_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  abadapt_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  delay_based_alpha_beta_adapt_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [15:0] p_thr;
  logic [7:0]  p_good;
  logic [31:0] p_min, p_peak, p_end, p_loss_win;
  logic [37:0] p_sum;
  logic [15:0] p_count;
  logic [10:0] p_gain;
  logic [5:0]  p_beta;
  logic [7:0]  p_low;
  logic        p_above;

  abadapt_pkg::in_item_t  pending_q[$];
  abadapt_pkg::out_item_t expected_q[$];
  int n_accepted = 0, n_results = 0, n_errors = 0, n_closed = 0, n_ssth = 0;
  int gap_left = 0, burst_left = 1, pat_mode = 0, pat_left = 0, hold_cnt = 0;
  logic long_hold = 1'b0, hold_done = 1'b0;
  logic next_valid;

  // generator-side tracking of round end and delay floor
  logic [31:0] g_end = '0;
  logic [31:0] g_floor = 32'd1000;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    n_errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic void clear_round(input logic [31:0] nxt);
    p_end = nxt;
    p_count = '0;
    p_sum = '0;
  endfunction

  function automatic void clear_all(input logic [31:0] nxt);
    p_gain = abadapt_pkg::GAIN_MAX;
    p_beta = abadapt_pkg::BETA_HI;
    p_min = abadapt_pkg::MIN_RTT_RESET;
    p_peak = '0;
    p_low = '0;
    p_above = 1'b0;
    p_loss_win = 32'd2;
    clear_round(nxt);
  endfunction

  function automatic logic [10:0] gain_update(input logic [31:0] da, input logic [31:0] dm);
    logic [31:0] d1, num, den, q;
    d1 = dm / 32'd100;
    if (da <= d1) begin
      if (!p_above) return abadapt_pkg::GAIN_MAX;
      p_low = p_low + 8'd1;
      if (p_low < p_good) return p_gain;
      p_low = '0;
      p_above = 1'b0;
      return abadapt_pkg::GAIN_MAX;
    end
    p_above = 1'b1;
    dm = dm - d1;
    da = da - d1;
    num = dm * 32'd1280;
    den = dm + (da * abadapt_pkg::GAIN_SPAN) / abadapt_pkg::GAIN_MIN;
    if (den == 32'd0) return abadapt_pkg::GAIN_MAX;
    q = num / den;
    return q[10:0];
  endfunction

  function automatic logic [5:0] beta_update(input logic [31:0] da, input logic [31:0] dm);
    logic [31:0] d2, d3;
    d2 = dm / 32'd20;
    d3 = (32'd8 * dm) / 32'd10;
    return (da >= d3 || d3 <= d2) ? abadapt_pkg::BETA_HI : abadapt_pkg::BETA_LO;
  endfunction

  function automatic abadapt_pkg::out_item_t predict_result(input abadapt_pkg::in_item_t it);
    abadapt_pkg::out_item_t o;
    logic [31:0] r, diff, dm, avg, da;
    logic [63:0] cut, a, h, ssth;
    logic [37:0] q;
    ssth = '0;
    o = '0;
    case (it.func)
      abadapt_pkg::FUNC_INIT: clear_all(it.next_seq);
      abadapt_pkg::FUNC_SAMPLE: begin
        if (!it.rtt_sample[31]) begin
          r = (it.rtt_sample > abadapt_pkg::RTT_CLAMP) ? abadapt_pkg::RTT_CLAMP : it.rtt_sample;
          if (p_min > r) p_min = r;
          if (p_peak < r) p_peak = r;
          if (p_count < 16'hffff) begin
            p_count = p_count + 16'd1;
            p_sum = p_sum + {6'd0, r};
          end
        end
      end
      abadapt_pkg::FUNC_ACK: begin
        diff = it.ack_seq - p_end;
        if (diff != 32'd0 && !diff[31]) begin
          if (it.cwnd < {16'd0, p_thr}) begin
            p_gain = abadapt_pkg::GAIN_BASE;
            p_beta = abadapt_pkg::BETA_HI;
          end else if (p_count > 16'd0) begin
            dm = p_peak - p_min;
            q = p_sum / {22'd0, p_count};
            avg = q[31:0];
            da = avg - p_min;
            p_gain = gain_update(da, dm);
            p_beta = beta_update(da, dm);
          end
          clear_round(it.next_seq);
          o.round_ended = 1'b1;
        end
      end
      abadapt_pkg::FUNC_LOSS: begin
        p_gain = abadapt_pkg::GAIN_BASE;
        p_beta = abadapt_pkg::BETA_HI;
        p_low = '0;
        p_above = 1'b0;
        clear_round(it.next_seq);
      end
      abadapt_pkg::FUNC_SSTH: begin
        cut = ({32'd0, it.cwnd} * {58'd0, p_beta}) >> 6;
        a = {32'd0, it.cwnd} - cut;
        h = {32'd0, it.cwnd / 32'd2};
        p_loss_win = it.cwnd;
        ssth = (a > h) ? a : h;
      end
      default: ;
    endcase
    o.alpha_gain = p_gain;
    o.beta_factor = p_beta;
    o.ssthresh = ssth[31:0];
    return o;
  endfunction

  // sender: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_result(in_item));
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          in_item <= pending_q.pop_front();
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // receiver: compare and stall on a pattern of its own
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report("result with nothing expected", 0, 0);
        end else begin
          abadapt_pkg::out_item_t e;
          e = expected_q.pop_front();
          if (out_item.alpha_gain !== e.alpha_gain)
            report("alpha_gain", out_item.alpha_gain, e.alpha_gain);
          if (out_item.beta_factor !== e.beta_factor)
            report("beta_factor", out_item.beta_factor, e.beta_factor);
          if (out_item.ssthresh !== e.ssthresh)
            report("ssthresh", out_item.ssthresh, e.ssthresh);
          if (out_item.round_ended !== e.round_ended)
            report("round_ended", out_item.round_ended, e.round_ended);
          if (e.round_ended) n_closed++;
          if (e.ssthresh != 0) n_ssth++;
        end
      end
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 200);
      end else begin
        pat_left--;
      end
      out_stall <= long_hold || (pat_mode == 1 && $urandom_range(0, 3) == 0) ||
                   (pat_mode == 2 && $urandom_range(0, 1) == 1) ||
                   (pat_mode == 3 && $urandom_range(0, 3) != 0);
    end
  end

  // one long hold-off on the result side while items keep coming
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 1'b0;
    end else if (long_hold) begin
      if (hold_cnt == 0) long_hold <= 1'b0;
      else hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && n_accepted >= 300) begin
      long_hold <= 1'b1;
      hold_cnt <= 2000;
      hold_done <= 1'b1;
    end
  end

  task automatic add_item(input logic [2:0] f, input logic [31:0] rtt, input logic [31:0] ack,
                          input logic [31:0] nxt, input logic [31:0] cw);
    abadapt_pkg::in_item_t it;
    logic [31:0] diff;
    it.func = f;
    it.rtt_sample = rtt;
    it.ack_seq = ack;
    it.next_seq = nxt;
    it.cwnd = cw;
    pending_q.push_back(it);
    diff = ack - g_end;
    if (f == abadapt_pkg::FUNC_INIT || f == abadapt_pkg::FUNC_LOSS ||
        (f == abadapt_pkg::FUNC_ACK && diff != 0 && !diff[31]))
      g_end = nxt;
  endtask

  function automatic logic [31:0] pick_cwnd();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 20);
      1: return {16'd0, p_thr} + $urandom_range(0, 2) - 1;
      2: return $urandom;
      default: return $urandom_range(100, 100000);
    endcase
  endfunction

  task automatic add_round(input bit quiet);
    int n;
    logic [31:0] ack;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if (quiet) add_item(abadapt_pkg::FUNC_SAMPLE, g_floor, 0, 0, 0);
      else add_item(abadapt_pkg::FUNC_SAMPLE, g_floor + $urandom_range(0, 60000), 0, 0, 0);
    end
    if ($urandom_range(0, 9) == 0)
      add_item(abadapt_pkg::FUNC_ACK, 0, g_end, $urandom, pick_cwnd());
    ack = g_end + $urandom_range(1, 5000);
    add_item(abadapt_pkg::FUNC_ACK, $urandom, ack, ack + $urandom_range(0, 20000), pick_cwnd());
  endtask

  task automatic add_random(input int count);
    int start;
    start = pending_q.size();
    while (pending_q.size() - start < count) begin
      case ($urandom_range(0, 19))
        0: begin
          g_floor = $urandom_range(1, 200000);
          add_item(abadapt_pkg::FUNC_INIT, $urandom, $urandom, $urandom, $urandom);
        end
        1: add_item(abadapt_pkg::FUNC_LOSS, $urandom, $urandom, $urandom, $urandom);
        2, 3: add_item(abadapt_pkg::FUNC_SSTH, $urandom, $urandom, $urandom, pick_cwnd());
        4: add_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
        5: add_item(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
        6: add_item(abadapt_pkg::FUNC_SAMPLE, $urandom, 0, 0, 0);
        7: add_item(abadapt_pkg::FUNC_ACK, 0, $urandom, $urandom, $urandom);
        default: add_round($urandom_range(0, 1));
      endcase
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == abadapt_pkg::REG_WINDOW_THRESHOLD) p_thr = val;
    else if (idx == abadapt_pkg::REG_GOOD_RTT_NEEDED) p_good = val[7:0];
  endtask

  initial begin
    p_thr = abadapt_pkg::WTHR_RESET;
    p_good = abadapt_pkg::GOOD_RESET;
    clear_all('0);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes and corner cases
    add_item(abadapt_pkg::FUNC_INIT, 0, 0, 1000, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 0, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 100, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 3355443, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 3355444, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 32'h7fffffff, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 32'h80000000, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 32'hffffffff, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_ACK, 0, 1000, 2000, 32'hffffffff);   // on round end: no close
    add_item(abadapt_pkg::FUNC_ACK, 0, 995, 2000, 32'hffffffff);    // behind
    add_item(abadapt_pkg::FUNC_ACK, 0, 1001, 2000, 32'hffffffff);
    add_item(abadapt_pkg::FUNC_ACK, 0, 2001, 3000, 0);              // below threshold
    add_item(abadapt_pkg::FUNC_ACK, 0, 3001, 4000, 1000);           // no samples
    add_item(abadapt_pkg::FUNC_LOSS, 0, 0, 5000, 0);
    add_item(abadapt_pkg::FUNC_SSTH, 0, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_SSTH, 0, 0, 0, 32'hffffffff);
    add_item(abadapt_pkg::FUNC_SSTH, 0, 0, 0, 1000);
    add_item(3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_item(3'd6, 0, 0, 0, 0);
    add_item(3'd7, 1, 1, 1, 1);
    add_item(abadapt_pkg::FUNC_INIT, 0, 0, 32'hffffffff, 0);
    add_item(abadapt_pkg::FUNC_SAMPLE, 50, 0, 0, 0);
    add_item(abadapt_pkg::FUNC_ACK, 0, 32'h10, 32'h20, 100);        // sequence wrap
    add_random(330);
    wait_idle();

    write_reg(abadapt_pkg::REG_WINDOW_THRESHOLD, 16'd0);
    write_reg(abadapt_pkg::REG_GOOD_RTT_NEEDED, 16'd0);
    add_random(200);
    add_random(150);
    wait_idle();

    write_reg(abadapt_pkg::REG_WINDOW_THRESHOLD, 16'hffff);
    write_reg(abadapt_pkg::REG_GOOD_RTT_NEEDED, 16'd255);
    add_random(350);
    wait_idle();

    write_reg(abadapt_pkg::REG_WINDOW_THRESHOLD, 16'($urandom_range(1, 200)));
    write_reg(abadapt_pkg::REG_GOOD_RTT_NEEDED, 16'($urandom_range(1, 4)));
    add_random(400);
    wait_idle();
    repeat (300) @(posedge clk);

    $display("covered %0d items, %0d results, %0d closed rounds, %0d nonzero ssthresh",
             n_accepted, n_results, n_closed, n_ssth);
    $display("four register settings incl. extremes, one long result hold-off");
    if (n_errors == 0) begin
      $display("PASS delay_based_alpha_beta_adapt_top");
    end else begin
      $display("FAIL delay_based_alpha_beta_adapt_top");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout");
    $display("FAIL delay_based_alpha_beta_adapt_top");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/abadapt_pkg.sv
rtl/abadapt_div.sv
rtl/abadapt_dp.sv
rtl/abadapt_ctrl.sv
rtl/delay_based_alpha_beta_adapt_top.sv
bench/tb.sv
